FILE: rtl/i2a_pkg.sv
// Shared types, constants and the glyph function of the integer-to-ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Fixed field widths of the channels
    localparam int VALUE_BITS  = 64;
    localparam int CONV_BITS   = 3;
    localparam int CHAR_BITS   = 7;

    // Narrow operand width and its padded hex length
    localparam int NARROW_BITS       = 32;
    localparam int PAD_NARROW_DIGITS = 8;

    // Digit arithmetic
    localparam logic [3:0] DEC_RADIX = 4'd10;
    localparam logic [3:0] DAB_LIMIT = 4'd5;
    localparam logic [3:0] DAB_ADJ   = 4'd3;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 7'h2d;
    localparam logic [CHAR_BITS-1:0] CH_X       = 7'h78;

    typedef enum logic [CONV_BITS-1:0] {
        CONV_SDEC   = 3'd0,
        CONV_UDEC   = 3'd1,
        CONV_OCT    = 3'd2,
        CONV_HEX    = 3'd3,
        CONV_PADHEX = 3'd4,
        CONV_PTR    = 3'd5
    } conv_t;

    typedef enum logic [1:0] {
        DOP_HOLD,
        DOP_LOAD,
        DOP_DABBLE,
        DOP_SHIFT
    } dop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_PRE_A,
        ST_PRE_B,
        ST_DIGITS
    } state_t;

    // Control from the sequencer to the digit register
    typedef struct packed {
        dop_t  op;
        conv_t mode;
        logic  wide;
        logic  negate;
    } dig_ctl_t;

    // One character headed for the output register
    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } char_t;

    // Map a digit 0..15 to '0'..'9', 'a'..'f'
    function automatic logic [CHAR_BITS-1:0] glyph(input logic [3:0] d);
        logic [CHAR_BITS-1:0] g;
        if (d < DEC_RADIX)
        begin
            g = CH_ZERO + {3'b000, d};
        end
        else
        begin
            g = CH_LOWER_A + {3'b000, d} - {3'b000, DEC_RADIX};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/i2a_in_if.sv
// Input channel: operand, conversion code and width flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface i2a_in_if;
    import i2a_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [CONV_BITS-1:0]  conversion;
    logic                  wide;

    modport source (output valid, output value, output conversion, output wide, input ready);
    modport sink   (input valid, input value, input conversion, input wide, output ready);
endinterface

`default_nettype wire

FILE: rtl/i2a_out_if.sv
// Output channel: one ASCII character and a last marker with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface i2a_out_if;
    import i2a_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/integer_to_ascii_radix_unit.sv
// Integer-to-ASCII converter: one operand in, its characters out, most significant first.
//
// in_ch carries value, conversion and wide; out_ch carries one character per
// transfer with last set on the final character of the number.
// Conversions: signed decimal, unsigned decimal, octal, minimal hex, padded
// hex and pointer form ("0x" and minimal hex of a WORD_BITS-bit operand).
// Unused conversion codes are taken and give no characters.
// One operand is in work at a time; in_ch.ready is high only while idle.
// Decimal forms run a shift-add-3 pass over the operand, one bit per cycle:
// all 32 bits of a narrow operand, WORD_BITS bits of a wide one. Then the digit
// register shifts out one digit per cycle over WORD_BITS/3+1 slots, leading
// zeros dropped one per cycle; a kept digit waits while out_ch stalls.
// Octal, hex and pointer forms load their digits directly and skip that pass.
// A registered output stage holds each character; while out_ch stalls the
// converter holds its digits, and the next operand is taken as soon as the
// last character sits in that stage. Reset clears the sequencer and the
// output valid; no character is lost or repeated across a stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix_unit #(
    parameter int WORD_BITS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    i2a_in_if.sink     in_ch,
    i2a_out_if.source  out_ch
);
    import i2a_pkg::*;

    dig_ctl_t   dig_ctl;
    char_t      emit;
    logic [3:0] top_digit;
    logic       sign;
    logic       out_free;

    logic                 out_valid_reg;
    logic [CHAR_BITS-1:0] out_char_reg;
    logic                 out_last_reg;

    assign sign     = in_ch.wide ? in_ch.value[WORD_BITS-1] : in_ch.value[NARROW_BITS-1];
    assign out_free = !out_valid_reg || out_ch.ready;

    i2a_ctrl #(
        .W (WORD_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .conversion (in_ch.conversion),
        .wide       (in_ch.wide),
        .sign       (sign),
        .in_ready   (in_ch.ready),
        .top_digit  (top_digit),
        .out_free   (out_free),
        .dig_ctl    (dig_ctl),
        .emit       (emit)
    );

    i2a_digits #(
        .W (WORD_BITS)
    ) u_digits (
        .clk       (clk),
        .ctl       (dig_ctl),
        .value     (in_ch.value),
        .top_digit (top_digit)
    );

    // Output stage valid: set on a new character, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_char_reg <= emit.character;
            out_last_reg <= emit.last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.character = out_char_reg;
    assign out_ch.last      = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/i2a_digits.sv
// Digit shift register: loads hex/octal digits, runs shift-add-3 for decimal, shifts out MSD.
`timescale 1ns / 1ps
`default_nettype none

module i2a_digits #(
    parameter int W = 64
) (
    input  wire logic                           clk,
    input  wire i2a_pkg::dig_ctl_t              ctl,
    input  wire logic [i2a_pkg::VALUE_BITS-1:0] value,
    output logic [3:0]                          top_digit
);
    import i2a_pkg::*;

    localparam int NDIG = W / 3 + 1;

    logic [3:0]   dig_reg  [NDIG];
    logic [3:0]   dig_next [NDIG];
    logic [3:0]   adj      [NDIG];
    logic [W-1:0] bin_reg;
    logic [W-1:0] bin_next;

    logic [W-1:0]        op_v;
    logic [W-1:0]        neg_full;
    logic [W-1:0]        mag;
    logic [4*NDIG-1:0]   hex_ext;
    logic [3*NDIG-1:0]   oct_ext;

    // Select operand width and take the magnitude
    always_comb
    begin
        op_v     = ctl.wide ? value[W-1:0] : W'(value[NARROW_BITS-1:0]);
        neg_full = '0 - op_v;
        if (ctl.negate)
        begin
            mag = ctl.wide ? neg_full : W'(neg_full[NARROW_BITS-1:0]);
        end
        else
        begin
            mag = op_v;
        end
        hex_ext = (4*NDIG)'(mag);
        oct_ext = (3*NDIG)'(mag);
    end

    // Add three to every BCD digit of five or more
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (dig_reg[i] >= DAB_LIMIT) ? dig_reg[i] + DAB_ADJ : dig_reg[i];
        end
    end

    // Next value of the digit and binary registers
    always_comb
    begin
        bin_next = bin_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        case (ctl.op)
            DOP_LOAD:
            begin
                bin_next = ctl.wide ? mag : (mag << (W - NARROW_BITS));
                for (int i = 0; i < NDIG; i++)
                begin
                    case (ctl.mode)
                        CONV_OCT:                        dig_next[i] = {1'b0, oct_ext[3*i +: 3]};
                        CONV_HEX, CONV_PADHEX, CONV_PTR: dig_next[i] = hex_ext[4*i +: 4];
                        default:                         dig_next[i] = 4'd0;
                    endcase
                end
            end
            DOP_DABBLE:
            begin
                bin_next    = {bin_reg[W-2:0], 1'b0};
                dig_next[0] = {adj[0][2:0], bin_reg[W-1]};
                for (int i = 1; i < NDIG; i++)
                begin
                    dig_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
            end
            DOP_SHIFT:
            begin
                dig_next[0] = 4'd0;
                for (int i = 1; i < NDIG; i++)
                begin
                    dig_next[i] = dig_reg[i-1];
                end
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    // Hold digits and binary operand
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
    end

    assign top_digit = dig_reg[NDIG-1];

endmodule

`default_nettype wire

FILE: rtl/i2a_ctrl.sv
// Sequencer: accepts an operand, counts conversion steps, emits prefix and digits.
`timescale 1ns / 1ps
`default_nettype none

module i2a_ctrl #(
    parameter int W = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [i2a_pkg::CONV_BITS-1:0] conversion,
    input  wire logic                          wide,
    input  wire logic                          sign,
    output logic                               in_ready,
    input  wire logic [3:0]                    top_digit,
    input  wire logic                          out_free,
    output i2a_pkg::dig_ctl_t                  dig_ctl,
    output i2a_pkg::char_t                     emit
);
    import i2a_pkg::*;

    localparam int NDIG = W / 3 + 1;
    localparam int CW   = $clog2(W + 1);
    localparam int RW   = $clog2(NDIG + 1);

    localparam logic [CW-1:0] CNT_WIDE   = CW'(W);
    localparam logic [CW-1:0] CNT_NARROW = CW'(NARROW_BITS);
    localparam logic [RW-1:0] REM_FULL   = RW'(NDIG);
    localparam logic [RW-1:0] REM_ONE    = RW'(1);
    localparam logic [RW-1:0] PAD_WIDE   = RW'(W / 4);
    localparam logic [RW-1:0] PAD_NARROW = RW'(PAD_NARROW_DIGITS);

    state_t        state_reg, state_next;
    conv_t         mode_reg, mode_next;
    logic          neg_reg, neg_next;
    logic          wide_reg, wide_next;
    logic          lead_reg, lead_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, rem_next;

    conv_t         in_conv;
    logic          in_neg;
    logic [RW-1:0] pad;
    logic          skip;
    logic          fire;

    assign in_conv = conv_t'(conversion);
    assign in_neg  = (in_conv == CONV_SDEC) && sign;
    assign pad     = wide_reg ? PAD_WIDE : PAD_NARROW;

    // Drop leading zeros in minimal forms; drop unused upper slots in padded hex
    assign skip = (mode_reg == CONV_PADHEX) ? (rem_reg > pad)
                : (lead_reg && (top_digit == 4'd0) && (rem_reg > REM_ONE));
    assign fire = (state_reg == ST_DIGITS) && !skip && out_free;

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        neg_next   = neg_reg;
        wide_next  = wide_reg;
        lead_next  = lead_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = in_conv;
                    neg_next  = in_neg;
                    wide_next = wide;
                    lead_next = 1'b1;
                    cnt_next  = wide ? CNT_WIDE : CNT_NARROW;
                    rem_next  = REM_FULL;
                    case (in_conv)
                        CONV_SDEC, CONV_UDEC:            state_next = ST_DABBLE;
                        CONV_OCT, CONV_HEX, CONV_PADHEX: state_next = ST_DIGITS;
                        CONV_PTR:                        state_next = ST_PRE_A;
                        default:                         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DABBLE:
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = neg_reg ? ST_PRE_A : ST_DIGITS;
                end
            end
            ST_PRE_A:
            begin
                if (out_free)
                begin
                    state_next = (mode_reg == CONV_PTR) ? ST_PRE_B : ST_DIGITS;
                end
            end
            ST_PRE_B:
            begin
                if (out_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (skip || fire)
                begin
                    rem_next = rem_reg - REM_ONE;
                end
                // keep every zero once the first digit is out
                if (fire)
                begin
                    lead_next = 1'b0;
                end
                if (fire && (rem_reg == REM_ONE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake, digit register control, character strobe
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        dig_ctl.op     = DOP_HOLD;
        dig_ctl.mode   = in_conv;
        dig_ctl.wide   = wide || (in_conv == CONV_PTR);
        dig_ctl.negate = in_neg;
        emit.valid     = 1'b0;
        emit.character = glyph(top_digit);
        emit.last      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dig_ctl.op = DOP_LOAD;
                end
            end
            ST_DABBLE:
            begin
                dig_ctl.op = DOP_DABBLE;
            end
            ST_PRE_A:
            begin
                emit.valid     = out_free;
                emit.character = (mode_reg == CONV_PTR) ? CH_ZERO : CH_MINUS;
            end
            ST_PRE_B:
            begin
                emit.valid     = out_free;
                emit.character = CH_X;
            end
            ST_DIGITS:
            begin
                if (skip || fire)
                begin
                    dig_ctl.op = DOP_SHIFT;
                end
                emit.valid = fire;
                emit.last  = (rem_reg == REM_ONE);
            end
            default:
            begin
                emit.valid = 1'b0;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= CONV_SDEC;
            neg_reg   <= 1'b0;
            wide_reg  <= 1'b0;
            lead_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            neg_reg   <= neg_next;
            wide_reg  <= wide_next;
            lead_reg  <= lead_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/integer_to_ascii_radix_unit_tb.sv
// Self-checking testbench of the integer-to-ASCII converter: directed table, then random operands.
`timescale 1ns / 1ps

module integer_to_ascii_radix_unit_tb;
    import i2a_pkg::*;

    localparam int WORD_BITS       = 64;
    localparam int RESET_CYCLES    = 6;
    localparam int DIRECTED_ROWS   = 26;
    localparam int RANDOM_ITEMS    = 90;
    localparam int CALM_ITEMS      = 25;
    localparam int HOLD_OFF_ITEM   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 150;
    localparam int QUIET_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 100;

    // Conversion codes the block leaves unused
    localparam logic [CONV_BITS-1:0] CONV_SPARE_LO = 3'd6;
    localparam logic [CONV_BITS-1:0] CONV_SPARE_HI = 3'd7;

    localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } ascii_char_t;

    // One operand of the directed table; typed rows carry their text
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [CONV_BITS-1:0]  conversion;
        logic                  wide;
        bit                    typed;
        string                 text;
    } directed_row_t;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{64'h0000_0000_0000_0000, CONV_SDEC,     1'b0, 1'b1, "0"},
        '{64'h0000_0000_0000_0000, CONV_UDEC,     1'b1, 1'b1, "0"},
        '{64'h0000_0000_0000_0000, CONV_OCT,      1'b1, 1'b1, "0"},
        '{64'h0000_0000_0000_0000, CONV_HEX,      1'b0, 1'b1, "0"},
        '{64'h0000_0000_0000_0000, CONV_PADHEX,   1'b0, 1'b1, "00000000"},
        '{64'h0000_0000_0000_0000, CONV_PADHEX,   1'b1, 1'b1, "0000000000000000"},
        '{64'h0000_0000_0000_0000, CONV_PTR,      1'b0, 1'b1, "0x0"},
        '{64'hffff_ffff_8000_0000, CONV_SDEC,     1'b0, 1'b1, "-2147483648"},
        '{64'h8000_0000_0000_0000, CONV_SDEC,     1'b1, 1'b1, "-9223372036854775808"},
        '{ALL_ONES,                CONV_SDEC,     1'b1, 1'b1, "-1"},
        '{64'h0000_0000_7fff_ffff, CONV_SDEC,     1'b0, 1'b1, "2147483647"},
        '{64'h7fff_ffff_ffff_ffff, CONV_SDEC,     1'b1, 1'b1, "9223372036854775807"},
        '{ALL_ONES,                CONV_UDEC,     1'b1, 1'b1, "18446744073709551615"},
        '{ALL_ONES,                CONV_UDEC,     1'b0, 1'b1, "4294967295"},
        '{ALL_ONES,                CONV_OCT,      1'b1, 1'b1, "1777777777777777777777"},
        '{ALL_ONES,                CONV_OCT,      1'b0, 1'b1, "37777777777"},
        '{ALL_ONES,                CONV_HEX,      1'b1, 1'b1, "ffffffffffffffff"},
        '{64'h1234_5678_dead_beef, CONV_HEX,      1'b0, 1'b1, "deadbeef"},
        '{64'hffff_ffff_0000_000a, CONV_PADHEX,   1'b0, 1'b1, "0000000a"},
        '{64'h0123_4567_89ab_cdef, CONV_PADHEX,   1'b1, 1'b1, "0123456789abcdef"},
        '{64'h1234_5678_9abc_def0, CONV_PTR,      1'b0, 1'b1, "0x123456789abcdef0"},
        '{ALL_ONES,                CONV_PTR,      1'b1, 1'b1, "0xffffffffffffffff"},
        '{64'h0000_0000_ffff_ffff, CONV_SPARE_LO, 1'b1, 1'b1, ""},
        '{ALL_ONES,                CONV_SPARE_HI, 1'b0, 1'b1, ""},
        '{64'hfedc_ba98_7654_3210, CONV_SDEC,     1'b1, 1'b0, ""},
        '{64'h0000_0000_8000_0001, CONV_OCT,      1'b0, 1'b0, ""}
    };

    logic clk = 1'b0;
    logic rst_n;

    i2a_in_if  in_ch ();
    i2a_out_if out_ch ();

    ascii_char_t expected_chars [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          chars_seen     = 0;
    bit          idling_on;
    bit          hold_off_wanted;
    bit          offered_typed;
    string       offered_text;

    integer_to_ascii_radix_unit #(
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Map one digit value to its character
    function automatic string digit_char(input int d);
        string glyphs;
        glyphs = "0123456789abcdef";
        return glyphs.substr(d, d);
    endfunction

    // Minimal digits of an unsigned operand, most significant first
    function automatic string minimal_digits(input logic [VALUE_BITS-1:0] operand,
                                             input logic [VALUE_BITS-1:0] radix);
        string digits;
        digits = "";
        do
        begin
            digits  = {digit_char(int'(operand % radix)), digits};
            operand = operand / radix;
        end
        while (operand != 0);
        return digits;
    endfunction

    // Predict the text of one operand under its conversion code
    function automatic string render_number(input logic [VALUE_BITS-1:0] value,
                                            input logic [CONV_BITS-1:0]  conversion,
                                            input logic                  wide);
        int                    operand_bits;
        int                    d;
        logic [VALUE_BITS-1:0] mask;
        logic [VALUE_BITS-1:0] word_mask;
        logic [VALUE_BITS-1:0] operand;
        string                 text;
        operand_bits = wide ? WORD_BITS : NARROW_BITS;
        word_mask = (WORD_BITS >= VALUE_BITS) ? ALL_ONES : ((64'd1 << WORD_BITS) - 64'd1);
        mask      = (operand_bits >= VALUE_BITS) ? ALL_ONES
                                                 : ((64'd1 << operand_bits) - 64'd1);
        operand   = value & mask;
        text      = "";
        case (conversion)
            CONV_SDEC:
            begin
                // negative values print a minus and the wrapped magnitude
                if (operand[operand_bits-1])
                begin
                    text    = "-";
                    operand = (~operand + 64'd1) & mask;
                end
                text = {text, minimal_digits(operand, 64'd10)};
            end
            CONV_UDEC:
            begin
                text = minimal_digits(operand, 64'd10);
            end
            CONV_OCT:
            begin
                text = minimal_digits(operand, 64'd8);
            end
            CONV_HEX:
            begin
                text = minimal_digits(operand, 64'd16);
            end
            CONV_PADHEX:
            begin
                for (d = operand_bits / 4 - 1; d >= 0; d--)
                begin
                    text = {text, digit_char(int'((operand >> (4 * d)) & 64'hf))};
                end
            end
            CONV_PTR:
            begin
                // the pointer form always takes the full word
                text = {"0x", minimal_digits(value & word_mask, 64'd16)};
            end
            default:
            begin
                text = "";
            end
        endcase
        return text;
    endfunction

    // Queue the characters of one number, marking the final one
    function automatic void expect_text(input string text);
        ascii_char_t entry;
        int          k;
        for (k = 0; k < text.len(); k++)
        begin
            entry.character = CHAR_BITS'(text[k]);
            entry.last      = (k == text.len() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("mismatch at character %0d: %s", chars_seen, what);
        end
        mismatch_count++;
    endtask

    // Spread operand values over small, boundary and full-width cases
    function automatic logic [VALUE_BITS-1:0] random_operand();
        logic [VALUE_BITS-1:0] raw;
        logic [VALUE_BITS-1:0] pick;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0:       pick = 64'($urandom_range(0, 999));
            1:       pick = raw >> $urandom_range(1, 63);
            2:       pick = {raw[63:32], 1'b1, raw[30:0]};
            3:       pick = 64'd1 << $urandom_range(0, 63);
            4:       pick = (64'd1 << $urandom_range(1, 63)) - 64'd1;
            5:       pick = ~(64'd1 << $urandom_range(0, 63)) + 64'd1;
            default: pick = raw;
        endcase
        return pick;
    endfunction

    // Offer one operand and hold it until the transfer; starts and ends at a falling edge
    task automatic offer_operand(input logic [VALUE_BITS-1:0] value,
                                 input logic [CONV_BITS-1:0]  conversion,
                                 input logic                  wide,
                                 input bit                    typed,
                                 input string                 text);
        int gap;
        // drop valid for a burst, with noise on the payload
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_ch.valid      <= 1'b0;
            in_ch.value      <= {$urandom, $urandom};
            in_ch.conversion <= CONV_BITS'($urandom_range(0, 7));
            in_ch.wide       <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= value;
        in_ch.conversion <= conversion;
        in_ch.wide       <= wide;
        offered_typed    = typed;
        offered_text     = text;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Predict on each operand transfer, check each character transfer
    always @(posedge clk)
    begin
        ascii_char_t want;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                expect_text(offered_typed ? offered_text
                                          : render_number(in_ch.value, in_ch.conversion,
                                                          in_ch.wide));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("character %02h with none expected",
                                              out_ch.character));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.character !== want.character)
                    begin
                        report_mismatch($sformatf("character %02h, expected %02h",
                                                  out_ch.character, want.character));
                    end
                    if (out_ch.last !== want.last)
                    begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  out_ch.last, want.last));
                    end
                end
                chars_seen++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Drive ready: random stall bursts, one long hold-off on request
    initial
    begin : char_receiver
        int  stall_left;
        int  hold_count;
        bit  hold_served;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        hold_served  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_wanted && !hold_served)
            begin
                hold_served  = 1'b1;
                out_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++)
                begin
                    @(negedge clk);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int                   row;
        int                   sent;
        logic [CONV_BITS-1:0] conversion;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.conversion = '0;
        in_ch.wide       = 1'b0;
        idling_on        = 1'b1;
        hold_off_wanted  = 1'b0;
        offered_typed    = 1'b0;
        offered_text     = "";
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            offer_operand(directed_rows[row].value, directed_rows[row].conversion,
                          directed_rows[row].wide, directed_rows[row].typed,
                          directed_rows[row].text);
        end

        // Random operands; ignored codes do not count, last stretch runs at full rate
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idling_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ((sent / 15) % 3 != 2);
            if (sent == HOLD_OFF_ITEM)
            begin
                hold_off_wanted = 1'b1;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                conversion = $urandom_range(0, 1) ? CONV_SPARE_HI : CONV_SPARE_LO;
            end
            else
            begin
                conversion = CONV_BITS'($urandom_range(0, 5));
            end
            offer_operand(random_operand(), conversion, 1'($urandom_range(0, 1)), 1'b0, "");
            if (conversion <= CONV_PTR)
            begin
                sent++;
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then allow for stray characters
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/i2a_pkg.sv
rtl/i2a_in_if.sv
rtl/i2a_out_if.sv
rtl/i2a_digits.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_radix_unit.sv
tb/integer_to_ascii_radix_unit_tb.sv
